[rtl/grid_weighted_smoothing_assert.svh]
// ----------------------------------------------------------------------------
// Grid weighted smoothing assertion macros
// Shared forms for the concurrent checks attached to the block.
// ----------------------------------------------------------------------------
`ifndef GRID_WEIGHTED_SMOOTHING_ASSERT_SVH
`define GRID_WEIGHTED_SMOOTHING_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GWS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("grid_weighted_smoothing check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GWS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("grid_weighted_smoothing check failed");

`endif

[rtl/gws_pkg.sv]
// ----------------------------------------------------------------------------
// Grid weighted smoothing package
// Codes, widths, the tap table and the accumulator control type.
// ----------------------------------------------------------------------------
`default_nettype none

package gws_pkg;

    localparam int COORD_W = 6;
    localparam int VALUE_W = 8;
    localparam int MODE_W  = 2;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 2;
    localparam int BOUND_W = 9;
    localparam int ACC_W   = 12;
    localparam int PROD_W  = 24;
    localparam int TAP_W   = 4;
    localparam int WT_W    = 2;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PASS  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PASS  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RECT_LEFT   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_RECT_TOP    = 2'd1;
    localparam logic [CFG_W-1:0] CFG_RECT_RIGHT  = 2'd2;
    localparam logic [CFG_W-1:0] CFG_RECT_BOTTOM = 2'd3;

    // Division by 15 as a multiply by 2185 and a shift by 15; exact for sums
    // up to 15 * 255.
    localparam logic [ACC_W-1:0] DIV15_MUL   = 12'd2185;
    localparam int               DIV15_SHIFT = 15;

    localparam logic [TAP_W-1:0] TAP_LAST = 4'd8;

    typedef struct packed {
        logic clear;
        logic add;
        logic div;
    } gws_acc_ctl_t;

    // Row offset plus one of a tap, taps in raster order over the 3x3 window.
    function automatic logic [1:0] tap_dy(input logic [TAP_W-1:0] tap);
        logic [1:0] dy;
        unique case (tap)
            4'd0, 4'd1, 4'd2: dy = 2'd0;
            4'd3, 4'd4, 4'd5: dy = 2'd1;
            default:          dy = 2'd2;
        endcase
        return dy;
    endfunction

    function automatic logic [1:0] tap_dx(input logic [TAP_W-1:0] tap);
        logic [1:0] dx;
        unique case (tap)
            4'd0, 4'd3, 4'd6: dx = 2'd0;
            4'd1, 4'd4, 4'd7: dx = 2'd1;
            default:          dx = 2'd2;
        endcase
        return dx;
    endfunction

    function automatic logic [WT_W-1:0] tap_weight(input logic [TAP_W-1:0] tap);
        logic [WT_W-1:0] w;
        unique case (tap)
            4'd0, 4'd2, 4'd6, 4'd8: w = 2'd1;
            4'd4:                   w = 2'd3;
            default:                w = 2'd2;
        endcase
        return w;
    endfunction

    function automatic logic [BOUND_W-1:0] clamp_bound(input logic [BOUND_W-1:0] v,
                                                       input logic [BOUND_W-1:0] hi);
        logic [BOUND_W-1:0] r;
        if (v < BOUND_W'(1)) begin
            r = BOUND_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/gws_store.sv]
// ----------------------------------------------------------------------------
// Grid weighted smoothing cell store
// Light level memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gws_store #(
    parameter int ADDR_W = 12
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [gws_pkg::VALUE_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    output logic      [gws_pkg::VALUE_W-1:0] rd_data
);
    import gws_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/gws_accum.sv]
// ----------------------------------------------------------------------------
// Grid weighted smoothing accumulator
// Shared weighted adder for the nine taps and the divide-by-15 multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module gws_accum (
    input  wire logic                        clk,
    input  wire gws_pkg::gws_acc_ctl_t       ctl,
    input  wire logic [gws_pkg::WT_W-1:0]    weight,
    input  wire logic [gws_pkg::VALUE_W-1:0] data,
    output logic      [gws_pkg::VALUE_W-1:0] quot
);
    import gws_pkg::*;

    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [ACC_W-1:0]  term;
    logic [ACC_W-1:0]  data_ext;

    assign data_ext = ACC_W'(data);

    always_comb
    begin
        unique case (weight)
            2'd1:    term = data_ext;
            2'd2:    term = data_ext << 1;
            2'd3:    term = data_ext + (data_ext << 1);
            default: term = '0;
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        prod_next = prod_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.add)
        begin
            acc_next = acc_reg + term;
        end
        if (ctl.div)
        begin
            prod_next = PROD_W'(acc_reg) * PROD_W'(DIV15_MUL);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign quot = prod_reg[DIV15_SHIFT +: VALUE_W];

endmodule

`default_nettype wire

[rtl/grid_weighted_smoothing.sv]
// ----------------------------------------------------------------------------
// Grid weighted smoothing
// Grid of light levels with cell access and an in-place 3x3 smoothing pass.
// ----------------------------------------------------------------------------
// A command is taken at a clock edge where start is high and busy is low;
// mode selects a cell write, a cell read or a smoothing pass over the
// configured rectangle. Each command yields exactly one result, shown for one
// cycle with result_valid high; the receiver cannot stall it.
// A write or an unused mode answers in the cycle after acceptance and never
// raises busy, so commands can follow every cycle. A read holds busy for one
// cycle and answers as busy falls. A pass handles each cell of the clamped
// rectangle: the nine tap reads through the single store read port, the add
// of the last tap, the divide-by-15 multiply and the write back of the cell.
// The result comes in the cycle after the last write back; an empty rectangle
// answers at once. The rectangle registers are written through the cfg
// channel, which is always ready; the user must write them only while no
// command is in flight, as the block does not enforce it. Reset clears the
// control state and sets the rectangle to 0 to 63 on both axes; the cell store
// is not cleared and must be loaded before it is read or smoothed.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_weighted_smoothing #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [gws_pkg::MODE_W-1:0]  mode,
    input  wire logic [gws_pkg::COORD_W-1:0] row,
    input  wire logic [gws_pkg::COORD_W-1:0] col,
    input  wire logic [gws_pkg::VALUE_W-1:0] value,
    output logic                             result_valid,
    output logic      [gws_pkg::KIND_W-1:0]  result_kind,
    output logic      [gws_pkg::VALUE_W-1:0] result_value,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [gws_pkg::CFG_W-1:0]   cfg_index,
    input  wire logic [gws_pkg::COORD_W-1:0] cfg_data
);
    import gws_pkg::*;

    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ADDR_W = ROW_W + COL_W;

    localparam logic [BOUND_W-1:0] W_LIM  = BOUND_W'(GRID_WIDTH);
    localparam logic [BOUND_W-1:0] H_LIM  = BOUND_W'(GRID_HEIGHT);
    localparam logic [BOUND_W-1:0] X_HI   = BOUND_W'(GRID_WIDTH - 2);
    localparam logic [BOUND_W-1:0] Y_HI   = BOUND_W'(GRID_HEIGHT - 2);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_TAP  = 3'd2;
    localparam logic [2:0] ST_LAST = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_WB   = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [COORD_W-1:0] rect_left_reg, rect_top_reg, rect_right_reg, rect_bottom_reg;
    logic [ROW_W-1:0]   y_reg, y_next, y1_reg, y1_next;
    logic [COL_W-1:0]   x_reg, x_next, x0_reg, x0_next, x1_reg, x1_next;
    logic [TAP_W-1:0]   tap_reg, tap_next;
    logic [WT_W-1:0]    wt_reg, wt_next;
    logic               inside_reg, inside_next;
    logic               strobe_reg, strobe_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [VALUE_W-1:0] value_reg, value_next;

    logic               accept;
    logic               in_grid;
    logic [BOUND_W-1:0] row_ext, col_ext;
    logic [ADDR_W-1:0]  port_addr;
    logic [BOUND_W-1:0] x0_b, x1_b, y0_b, y1_b;
    logic               pass_empty;
    logic [ROW_W-1:0]   tap_row;
    logic [COL_W-1:0]   tap_col;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic [VALUE_W-1:0] quot;
    gws_acc_ctl_t       acc_ctl;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign row_ext   = BOUND_W'(row);
    assign col_ext   = BOUND_W'(col);
    assign in_grid   = (row_ext < H_LIM) && (col_ext < W_LIM);
    assign port_addr = {row_ext[ROW_W-1:0], col_ext[COL_W-1:0]};

    assign x0_b       = clamp_bound(BOUND_W'(rect_left_reg), X_HI);
    assign x1_b       = clamp_bound(BOUND_W'(rect_right_reg), X_HI);
    assign y0_b       = clamp_bound(BOUND_W'(rect_top_reg), Y_HI);
    assign y1_b       = clamp_bound(BOUND_W'(rect_bottom_reg), Y_HI);
    assign pass_empty = (x0_b >= x1_b) || (y0_b >= y1_b);

    assign tap_row = y_reg + ROW_W'(tap_dy(tap_reg)) - ROW_W'(1);
    assign tap_col = x_reg + COL_W'(tap_dx(tap_reg)) - COL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg   <= COORD_W'(0);
            rect_top_reg    <= COORD_W'(0);
            rect_right_reg  <= COORD_W'(63);
            rect_bottom_reg <= COORD_W'(63);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RECT_LEFT:   rect_left_reg   <= cfg_data;
                CFG_RECT_TOP:    rect_top_reg    <= cfg_data;
                CFG_RECT_RIGHT:  rect_right_reg  <= cfg_data;
                CFG_RECT_BOTTOM: rect_bottom_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        y_next      = y_reg;
        y1_next     = y1_reg;
        x_next      = x_reg;
        x0_next     = x0_reg;
        x1_next     = x1_reg;
        tap_next    = tap_reg;
        wt_next     = wt_reg;
        inside_next = inside_reg;
        strobe_next = 1'b0;
        kind_next   = kind_reg;
        value_next  = value_reg;
        wr_en       = 1'b0;
        wr_addr     = port_addr;
        wr_data     = value;
        rd_addr     = port_addr;
        acc_ctl     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_WRITE:
                        begin
                            wr_en       = in_grid;
                            strobe_next = 1'b1;
                            kind_next   = KIND_WRITE;
                            value_next  = '0;
                        end
                        MODE_READ:
                        begin
                            inside_next = in_grid;
                            state_next  = ST_RD;
                        end
                        MODE_PASS:
                        begin
                            if (pass_empty)
                            begin
                                strobe_next = 1'b1;
                                kind_next   = KIND_PASS;
                                value_next  = '0;
                            end
                            else
                            begin
                                x0_next    = x0_b[COL_W-1:0];
                                x1_next    = x1_b[COL_W-1:0];
                                x_next     = x0_b[COL_W-1:0];
                                y_next     = y0_b[ROW_W-1:0];
                                y1_next    = y1_b[ROW_W-1:0];
                                tap_next   = '0;
                                state_next = ST_TAP;
                            end
                        end
                        MODE_NONE:
                        begin
                            strobe_next = 1'b1;
                            kind_next   = KIND_WRITE;
                            value_next  = '0;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_READ;
                value_next  = inside_reg ? rd_data : '0;
                state_next  = ST_IDLE;
            end
            ST_TAP:
            begin
                rd_addr     = {tap_row, tap_col};
                wt_next     = tap_weight(tap_reg);
                acc_ctl.clear = (tap_reg == '0);
                acc_ctl.add   = (tap_reg != '0);
                tap_next    = tap_reg + TAP_W'(1);
                if (tap_reg == TAP_LAST)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                acc_ctl.add = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                acc_ctl.div = 1'b1;
                state_next  = ST_WB;
            end
            ST_WB:
            begin
                wr_en    = 1'b1;
                wr_addr  = {y_reg, x_reg};
                wr_data  = quot;
                tap_next = '0;
                if (x_reg + COL_W'(1) == x1_reg)
                begin
                    x_next = x0_reg;
                    if (y_reg + ROW_W'(1) == y1_reg)
                    begin
                        strobe_next = 1'b1;
                        kind_next   = KIND_PASS;
                        value_next  = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        y_next     = y_reg + ROW_W'(1);
                        state_next = ST_TAP;
                    end
                end
                else
                begin
                    x_next     = x_reg + COL_W'(1);
                    state_next = ST_TAP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            kind_reg   <= KIND_WRITE;
            value_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            kind_reg   <= kind_next;
            value_reg  <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg      <= y_next;
        y1_reg     <= y1_next;
        x_reg      <= x_next;
        x0_reg     <= x0_next;
        x1_reg     <= x1_next;
        tap_reg    <= tap_next;
        wt_reg     <= wt_next;
        inside_reg <= inside_next;
    end

    gws_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gws_accum u_accum (
        .clk    (clk),
        .ctl    (acc_ctl),
        .weight (wt_reg),
        .data   (rd_data),
        .quot   (quot)
    );

    assign result_valid = strobe_reg;
    assign result_kind  = kind_reg;
    assign result_value = value_reg;

endmodule

`default_nettype wire

[rtl/gws_checker.sv]
// ----------------------------------------------------------------------------
// Grid weighted smoothing checker
// Port-level checks on command acceptance and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_weighted_smoothing_assert.svh"

module gws_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic [gws_pkg::MODE_W-1:0]  mode,
    input  wire logic                        result_valid,
    input  wire logic [gws_pkg::KIND_W-1:0]  result_kind,
    input  wire logic [gws_pkg::VALUE_W-1:0] result_value
);
    import gws_pkg::*;

    `GWS_ASSERT_IMP(a_value_zero, clk, rst_n, result_valid && (result_kind != KIND_READ), result_value == '0)
    `GWS_ASSERT_NXT(a_write_next, clk, rst_n, start && !busy && (mode == MODE_WRITE), result_valid && (result_kind == KIND_WRITE) && !busy)
    `GWS_ASSERT_NXT(a_read_two, clk, rst_n, start && !busy && (mode == MODE_READ), busy ##1 (result_valid && (result_kind == KIND_READ)))
    `GWS_ASSERT_NXT(a_pass_go, clk, rst_n, start && !busy && (mode == MODE_PASS), busy || (result_valid && (result_kind == KIND_PASS)))
    `GWS_ASSERT_IMP(a_busy_end, clk, rst_n, $fell(busy), result_valid)

endmodule

bind grid_weighted_smoothing gws_checker u_gws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .result_value (result_value)
);

`default_nettype wire

[verif/tb_grid_weighted_smoothing.sv]
// ----------------------------------------------------------------------------
// Grid weighted smoothing testbench
// Drives cell writes, cell reads, unused commands and smoothing passes over
// many rectangle settings, and checks every result against a cycle-free
// model of the grid that the bench keeps. Cells are always loaded before
// they are read or used by a pass. The sender idles at random in phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grid_weighted_smoothing;

    import gws_pkg::*;

    localparam int GRID_W       = 64;
    localparam int GRID_H       = 64;
    localparam int RANDOM_ITEMS = 840;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PRINT_LIMIT  = 50;
    localparam int IDLE_PHASES [3] = '{0, 74, 14};

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] level;
    } answer_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic [MODE_W-1:0]   mode        = MODE_WRITE;
    logic [COORD_W-1:0]  row         = '0;
    logic [COORD_W-1:0]  col         = '0;
    logic [VALUE_W-1:0]  value       = '0;
    logic                result_valid;
    logic [KIND_W-1:0]   result_kind;
    logic [VALUE_W-1:0]  result_value;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_index   = CFG_RECT_LEFT;
    logic [COORD_W-1:0]  cfg_data    = '0;

    answer_t             expected_answers [$];
    logic [VALUE_W-1:0]  level_grid [GRID_H][GRID_W];
    bit                  cell_loaded [GRID_H][GRID_W];
    int                  loaded_cells [$];
    logic [COORD_W-1:0]  box_left    = 6'd0;
    logic [COORD_W-1:0]  box_top     = 6'd0;
    logic [COORD_W-1:0]  box_right   = 6'd63;
    logic [COORD_W-1:0]  box_bottom  = 6'd63;
    int                  mismatch_count = 0;
    int                  items_sent  = 0;
    int                  idle_pct    = 0;
    int                  cycle_count = 0;

    grid_weighted_smoothing dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .row          (row),
        .col          (col),
        .value        (value),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .result_value (result_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int clamp_edge(input int v, input int hi);
        if (v < 1)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic void smooth_box();
        int x0;
        int x1;
        int y0;
        int y1;
        int unsigned acc;
        x0 = clamp_edge(int'(box_left), GRID_W - 2);
        x1 = clamp_edge(int'(box_right), GRID_W - 2);
        y0 = clamp_edge(int'(box_top), GRID_H - 2);
        y1 = clamp_edge(int'(box_bottom), GRID_H - 2);
        for (int y = y0; y < y1; y++)
        begin
            for (int x = x0; x < x1; x++)
            begin
                acc = 0;
                for (int dy = -1; dy <= 1; dy++)
                begin
                    for (int dx = -1; dx <= 1; dx++)
                    begin
                        acc += (3 - (dy < 0 ? -dy : dy) - (dx < 0 ? -dx : dx))
                               * int'(level_grid[y + dy][x + dx]);
                    end
                end
                level_grid[y][x] = VALUE_W'(acc / 15);
            end
        end
    endfunction

    function automatic answer_t predict_command(input logic [MODE_W-1:0]  m,
                                                input logic [COORD_W-1:0] r,
                                                input logic [COORD_W-1:0] c,
                                                input logic [VALUE_W-1:0] v);
        answer_t a;
        a.kind  = KIND_WRITE;
        a.level = '0;
        case (m)
            MODE_WRITE:
            begin
                level_grid[r][c] = v;
                if (!cell_loaded[r][c])
                begin
                    cell_loaded[r][c] = 1'b1;
                    loaded_cells.push_back(int'(r) * GRID_W + int'(c));
                end
            end
            MODE_READ:
            begin
                a.kind  = KIND_READ;
                a.level = level_grid[r][c];
            end
            MODE_PASS:
            begin
                smooth_box();
                a.kind = KIND_PASS;
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Sends one command transaction, records its expected answer, then may idle at random.
    task automatic issue_command(input logic [MODE_W-1:0]  m,
                                 input logic [COORD_W-1:0] r,
                                 input logic [COORD_W-1:0] c,
                                 input logic [VALUE_W-1:0] v);
        int gap = 0;
        start <= 1'b1;
        mode  <= m;
        row   <= r;
        col   <= c;
        value <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        expected_answers.push_back(predict_command(m, r, c, v));
        items_sent++;
        while ($urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_answers.size() != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [COORD_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_RECT_LEFT:   box_left   = d;
            CFG_RECT_TOP:    box_top    = d;
            CFG_RECT_RIGHT:  box_right  = d;
            CFG_RECT_BOTTOM: box_bottom = d;
            default:
            begin
            end
        endcase
    endtask

    task automatic write_box(input int l, input int t, input int r, input int b);
        wait_idle();
        write_reg(CFG_RECT_LEFT, COORD_W'(l));
        write_reg(CFG_RECT_TOP, COORD_W'(t));
        write_reg(CFG_RECT_RIGHT, COORD_W'(r));
        write_reg(CFG_RECT_BOTTOM, COORD_W'(b));
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_box();
        int l;
        int t;
        int r;
        int b;
        int span_x;
        int span_y;
        l = $urandom_range(63);
        t = $urandom_range(63);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5:
            begin
                r = l + $urandom_range(5);
                b = t + $urandom_range(5);
            end
            6:
            begin
                r = $urandom_range(l);
                b = $urandom_range(63);
            end
            7:
            begin
                l = 0;
                r = 63;
                b = t + $urandom_range(3, 1);
            end
            8:
            begin
                t = 0;
                b = 63;
                r = l + $urandom_range(3, 1);
            end
            default:
            begin
                r = $urandom_range(63);
                b = $urandom_range(63);
                span_x = clamp_edge(r, GRID_W - 2) - clamp_edge(l, GRID_W - 2);
                span_y = clamp_edge(b, GRID_H - 2) - clamp_edge(t, GRID_H - 2);
                if (span_x > 0 && span_y > 0 && span_x * span_y > 300)
                begin
                    b = t + 3;
                end
            end
        endcase
        write_box(l, t, r > 63 ? 63 : r, b > 63 ? 63 : b);
    endtask

    task automatic run_pass();
        int x0;
        int x1;
        int y0;
        int y1;
        x0 = clamp_edge(int'(box_left), GRID_W - 2);
        x1 = clamp_edge(int'(box_right), GRID_W - 2);
        y0 = clamp_edge(int'(box_top), GRID_H - 2);
        y1 = clamp_edge(int'(box_bottom), GRID_H - 2);
        if (x0 < x1 && y0 < y1)
        begin
            for (int y = y0 - 1; y <= y1; y++)
            begin
                for (int x = x0 - 1; x <= x1; x++)
                begin
                    if (!cell_loaded[y][x])
                    begin
                        issue_command(MODE_WRITE, COORD_W'(y), COORD_W'(x),
                                      VALUE_W'($urandom_range(255)));
                    end
                end
            end
        end
        issue_command(MODE_PASS, COORD_W'($urandom_range(63)), COORD_W'($urandom_range(63)),
                      VALUE_W'($urandom_range(255)));
    endtask

    task automatic read_back_box(input int count);
        int x0;
        int x1;
        int y0;
        int y1;
        x0 = clamp_edge(int'(box_left), GRID_W - 2);
        x1 = clamp_edge(int'(box_right), GRID_W - 2);
        y0 = clamp_edge(int'(box_top), GRID_H - 2);
        y1 = clamp_edge(int'(box_bottom), GRID_H - 2);
        if (x0 < x1 && y0 < y1)
        begin
            repeat (count)
            begin
                issue_command(MODE_READ, COORD_W'($urandom_range(y1 - 1, y0)),
                              COORD_W'($urandom_range(x1 - 1, x0)),
                              VALUE_W'($urandom_range(255)));
            end
        end
    endtask

    task automatic read_loaded_cell();
        int cell_idx;
        cell_idx = loaded_cells[$urandom_range(loaded_cells.size() - 1)];
        issue_command(MODE_READ, COORD_W'(cell_idx / GRID_W), COORD_W'(cell_idx % GRID_W),
                      VALUE_W'($urandom_range(255)));
    endtask

    task automatic test_cell_access();
        issue_command(MODE_WRITE, 6'd0, 6'd0, 8'h00);
        issue_command(MODE_WRITE, 6'd63, 6'd63, 8'hFF);
        issue_command(MODE_WRITE, 6'd0, 6'd63, 8'hAA);
        issue_command(MODE_WRITE, 6'd63, 6'd0, 8'h55);
        issue_command(MODE_READ, 6'd0, 6'd0, 8'hFF);
        issue_command(MODE_READ, 6'd63, 6'd63, 8'h00);
        issue_command(MODE_READ, 6'd0, 6'd63, 8'h00);
        issue_command(MODE_READ, 6'd63, 6'd0, 8'hFF);
    endtask

    task automatic test_unused_mode();
        issue_command(MODE_NONE, 6'd63, 6'd63, 8'hFF);
        issue_command(MODE_NONE, 6'd0, 6'd0, 8'h00);
    endtask

    task automatic test_corner_passes();
        write_box(0, 0, 2, 2);
        for (int y = 0; y < 3; y++)
        begin
            for (int x = 0; x < 3; x++)
            begin
                issue_command(MODE_WRITE, COORD_W'(y), COORD_W'(x), 8'hFF);
            end
        end
        run_pass();
        issue_command(MODE_READ, 6'd1, 6'd1, 8'h00);
        write_box(63, 63, 63, 63);
        run_pass();
    endtask

    task automatic test_random_traffic();
        int first;
        int pick;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            idle_pct = IDLE_PHASES[((items_sent - first) / 120) % 3];
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                issue_command(MODE_WRITE, COORD_W'($urandom_range(63)),
                              COORD_W'($urandom_range(63)), VALUE_W'($urandom_range(255)));
            end
            else if (pick < 78)
            begin
                read_loaded_cell();
            end
            else if (pick < 84)
            begin
                issue_command(MODE_NONE, COORD_W'($urandom_range(63)),
                              COORD_W'($urandom_range(63)), VALUE_W'($urandom_range(255)));
            end
            else
            begin
                if ($urandom_range(1) == 1)
                begin
                    pick_box();
                end
                run_pass();
                read_back_box(6);
            end
        end
    endtask

    task automatic test_grid_corners();
        idle_pct = 0;
        write_box(0, 0, 4, 4);
        run_pass();
        read_back_box(12);
        issue_command(MODE_READ, 6'd1, 6'd1, 8'h00);
        write_box(58, 58, 63, 63);
        run_pass();
        read_back_box(12);
        issue_command(MODE_READ, 6'd61, 6'd61, 8'h00);
        issue_command(MODE_READ, 6'd63, 6'd63, 8'h00);
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && result_valid)
        begin
            if (expected_answers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d value %0d",
                                          result_kind, result_value));
            end
            else
            begin
                want = expected_answers.pop_front();
                if (result_kind !== want.kind)
                begin
                    report_mismatch($sformatf("result_kind %0d, expected %0d",
                                              result_kind, want.kind));
                end
                if (result_value !== want.level)
                begin
                    report_mismatch($sformatf("result_value %0d, expected %0d",
                                              result_value, want.level));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_cell_access();
        test_unused_mode();
        test_corner_passes();
        test_random_traffic();
        test_grid_corners();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_answers.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
